>>> rtl/crcfr_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and the bytewise CRC-16 fold for the framed reply reader.
// No dependencies.
package crcfr_pkg;

	localparam logic [15:0] CRC_POLY = 16'h1021;
	localparam int unsigned BYTE_W   = 8;
	localparam int unsigned VALUE_W  = 32;

	typedef enum logic [1:0] {
		CMD_START   = 2'd0,
		CMD_BYTE    = 2'd1,
		CMD_TIMEOUT = 2'd2,
		CMD_NONE    = 2'd3
	} cmd_t;

	typedef enum logic {
		REG_DEVICE_ADDRESS = 1'b0,
		REG_RETRY_BUDGET   = 1'b1
	} reg_idx_t;

	typedef enum logic {
		KIND_TX   = 1'b0,
		KIND_DONE = 1'b1
	} kind_t;

	// one result item
	typedef struct packed {
		kind_t               kind;
		logic [BYTE_W-1:0]   tx_byte;
		logic [VALUE_W-1:0]  reply_value;
		logic [BYTE_W-1:0]   reply_status;
		logic                reply_valid;
		logic                last;
	} item_t;

	// MSB-first, no reflection
	function automatic logic [15:0] crc_fold(input logic [15:0] c, input logic [7:0] b);
		logic [15:0] x;
		x = c ^ {b, 8'h00};
		for (int i = 0; i < 8; i++) begin
			x = x[15] ? ((x << 1) ^ CRC_POLY) : (x << 1);
		end
		return x;
	endfunction

endpackage

>>> rtl/crcfr_out_fifo.sv
`timescale 1ns / 1ps
// Result queue: takes up to two items per cycle, hands out one.
// Depends on crcfr_pkg.
module crcfr_out_fifo #(
	parameter int DEPTH = 4
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push0,
	input  logic                        push1,
	input  crcfr_pkg::item_t            item0,
	input  crcfr_pkg::item_t            item1,
	input  logic                        pop,
	output crcfr_pkg::item_t            head_item,
	output logic [$clog2(DEPTH+1)-1:0]  count
);
	import crcfr_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	item_t            mem_q [DEPTH];
	logic [PTR_W-1:0] head_q, tail_q, tail1;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] n_push;

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	assign tail1     = ptr_inc(tail_q);
	assign n_push    = CNT_W'(push0) + CNT_W'(push1);
	assign head_item = mem_q[head_q];
	assign count     = count_q;

	always_ff @(posedge clk) begin
		if (push0) begin
			mem_q[tail_q] <= item0;
		end
		if (push1) begin
			mem_q[tail1] <= item1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			if (pop) begin
				head_q <= ptr_inc(head_q);
			end
			if (push1) begin
				tail_q <= ptr_inc(tail1);
			end else if (push0) begin
				tail_q <= tail1;
			end
			count_q <= count_q + n_push - CNT_W'(pop);
		end
	end

endmodule

>>> rtl/crc_framed_reply_reader_core.sv
`timescale 1ns / 1ps
// Top level of the CRC-framed serial request/reply reader.
// Depends on crcfr_pkg and crcfr_out_fifo.
//
// A start item sends the device address and the request code as two transmit
// items and seeds a CRC-16 (poly 0x1021, init 0, MSB first) with them. Received
// byte items then build a big-endian 32-bit value, a status byte and a two-byte
// expected CRC; a match finishes the request with reply_valid set, a mismatch or
// timeout resends the request while the retry budget lasts, and afterwards the
// request finishes with reply_value 0 and reply_valid clear. Bytes and timeouts
// while idle, and command code 3, give no result. Timing: an input item is
// registered, then handled by the combinational frame logic, whose results go
// into a small result queue, so a new item can be taken every cycle while the
// queue has room for two results. The output port delivers one result per
// cycle while out_stall is low; a start or a resend produces two results. An
// item passes the input register and the result queue before its first result.
// Configuration writes take effect at the next clock edge.
module crc_framed_reply_reader_core #(
	parameter int FIFO_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [7:0]  cfg_data,
	// input channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  command,
	input  logic [7:0]  request_code,
	input  logic [7:0]  rx_byte,
	// result channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic        kind,
	output logic [7:0]  tx_byte,
	output logic [31:0] reply_value,
	output logic [7:0]  reply_status,
	output logic        reply_valid,
	output logic        last
);
	import crcfr_pkg::*;

	localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

	// config registers
	logic [7:0]  dev_addr_q, retry_budget_q;

	// input stage
	logic        valid_s1;
	cmd_t        cmd_s1;
	logic [7:0]  code_s1, rx_s1;

	// frame state
	logic [15:0] crc_q,      crc_d;
	logic [2:0]  pos_q,      pos_d;
	logic [31:0] value_q,    value_d;
	logic [7:0]  status_q,   status_d;
	logic [7:0]  exp_hi_q,   exp_hi_d;
	logic [7:0]  attempts_q, attempts_d;
	logic [7:0]  saved_q,    saved_d;
	logic        busy_q,     busy_d;

	logic        consume, in_accept;
	logic        push0, push1, pop;
	item_t       item0, item1, head_item;
	logic [CNT_W-1:0] fifo_count;

	// handling an item may push two results; only take it with room for both
	assign consume   = valid_s1 && (fifo_count <= CNT_W'(FIFO_DEPTH - 2));
	assign in_stall  = valid_s1 && !consume;
	assign in_accept = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dev_addr_q     <= 8'd128;
			retry_budget_q <= 8'd2;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_DEVICE_ADDRESS: dev_addr_q     <= cfg_data;
				REG_RETRY_BUDGET:   retry_budget_q <= cfg_data;
				default:            ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_accept) begin
			valid_s1 <= 1'b1;
		end else if (consume) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			cmd_s1  <= cmd_t'(command);
			code_s1 <= request_code;
			rx_s1   <= rx_byte;
		end
	end

	// frame logic for the item in the input stage
	always_comb begin
		logic do_send, do_fail, do_ok;
		logic [15:0] crc_seed;
		do_send    = 1'b0;
		do_fail    = 1'b0;
		do_ok      = 1'b0;
		crc_d      = crc_q;
		pos_d      = pos_q;
		value_d    = value_q;
		status_d   = status_q;
		exp_hi_d   = exp_hi_q;
		attempts_d = attempts_q;
		saved_d    = saved_q;
		busy_d     = busy_q;
		push0      = 1'b0;
		push1      = 1'b0;
		item0      = '0;
		item1      = '0;

		if (consume) begin
			if (cmd_s1 == CMD_START) begin
				// a start also drops any request still running
				saved_d    = code_s1;
				attempts_d = retry_budget_q;
				status_d   = '0;
				exp_hi_d   = '0;
				do_send    = 1'b1;
			end else if (busy_q) begin
				unique case (cmd_s1)
					CMD_TIMEOUT: do_fail = 1'b1;
					CMD_BYTE: begin
						priority if (pos_q < 3'd4) begin
							value_d = {value_q[23:0], rx_s1};
							crc_d   = crc_fold(crc_q, rx_s1);
							pos_d   = pos_q + 3'd1;
						end else if (pos_q == 3'd4) begin
							status_d = rx_s1;
							crc_d    = crc_fold(crc_q, rx_s1);
							pos_d    = 3'd5;
						end else if (pos_q == 3'd5) begin
							exp_hi_d = rx_s1;
							pos_d    = 3'd6;
						end else begin
							if (crc_q == {exp_hi_q, rx_s1}) begin
								do_ok = 1'b1;
							end else begin
								do_fail = 1'b1;
							end
						end
					end
					default: ;
				endcase
			end
		end

		if (do_fail) begin
			if (attempts_q != 8'd0) begin
				attempts_d = attempts_q - 8'd1;
				do_send    = 1'b1;
			end else begin
				busy_d             = 1'b0;
				pos_d              = '0;
				push0              = 1'b1;
				item0.kind         = KIND_DONE;
				item0.reply_status = status_q;
				item0.last         = 1'b1;
			end
		end

		if (do_ok) begin
			busy_d             = 1'b0;
			pos_d              = '0;
			push0              = 1'b1;
			item0.kind         = KIND_DONE;
			item0.reply_value  = value_q;
			item0.reply_status = status_q;
			item0.reply_valid  = 1'b1;
			item0.last         = 1'b1;
		end

		// (re)send: address then request code, both folded into a fresh CRC
		crc_seed = crc_fold(16'h0000, dev_addr_q);
		if (do_send) begin
			crc_d         = crc_fold(crc_seed, saved_d);
			pos_d         = '0;
			value_d       = '0;
			busy_d        = 1'b1;
			push0         = 1'b1;
			push1         = 1'b1;
			item0.kind    = KIND_TX;
			item0.tx_byte = dev_addr_q;
			item1.kind    = KIND_TX;
			item1.tx_byte = saved_d;
			item1.last    = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q      <= '0;
			pos_q      <= '0;
			value_q    <= '0;
			status_q   <= '0;
			exp_hi_q   <= '0;
			attempts_q <= '0;
			saved_q    <= '0;
			busy_q     <= 1'b0;
		end else begin
			crc_q      <= crc_d;
			pos_q      <= pos_d;
			value_q    <= value_d;
			status_q   <= status_d;
			exp_hi_q   <= exp_hi_d;
			attempts_q <= attempts_d;
			saved_q    <= saved_d;
			busy_q     <= busy_d;
		end
	end

	assign out_valid = (fifo_count != '0);
	assign pop       = out_valid && !out_stall;

	crcfr_out_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_out_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push0     (push0),
		.push1     (push1),
		.item0     (item0),
		.item1     (item1),
		.pop       (pop),
		.head_item (head_item),
		.count     (fifo_count)
	);

	assign kind         = head_item.kind;
	assign tx_byte      = head_item.tx_byte;
	assign reply_value  = head_item.reply_value;
	assign reply_status = head_item.reply_status;
	assign reply_valid  = head_item.reply_valid;
	assign last         = head_item.last;

endmodule

>>> test/crcfr_reply_checker.sv
`timescale 1ns / 1ps
// Reply checker for the framed reply reader: mirrors the frame, CRC and retry
// logic, queues the expected result items and compares them on the result channel.
// Depends on crcfr_pkg.
module crcfr_reply_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [7:0]  cfg_data,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [1:0]  command,
	input  logic [7:0]  request_code,
	input  logic [7:0]  rx_byte,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic        kind,
	input  logic [7:0]  tx_byte,
	input  logic [31:0] reply_value,
	input  logic [7:0]  reply_status,
	input  logic        reply_valid,
	input  logic        last,
	output int          mismatches,
	output int          outstanding
);
	import crcfr_pkg::*;

	// register shadows
	logic [7:0]  dev_addr;
	logic [7:0]  retry_limit;

	// frame state
	logic [15:0] crc_run;
	logic [2:0]  frame_pos;
	logic [31:0] value_acc;
	logic [7:0]  status_seen;
	logic [7:0]  crc_hi;
	logic [7:0]  retries_left;
	logic [7:0]  code_saved;
	logic        active;

	item_t       reply_queue[$];

	function automatic logic [15:0] crc_byte(input logic [15:0] acc, input logic [7:0] b);
		logic [15:0] r;
		r = acc ^ {b, 8'h00};
		repeat (8) r = r[15] ? ({r[14:0], 1'b0} ^ CRC_POLY) : {r[14:0], 1'b0};
		return r;
	endfunction

	task automatic queue_result(input kind_t k, input logic [7:0] tx, input logic [31:0] v,
			input logic [7:0] st, input logic vld, input logic lst);
		item_t it;
		it.kind         = k;
		it.tx_byte      = tx;
		it.reply_value  = v;
		it.reply_status = st;
		it.reply_valid  = vld;
		it.last         = lst;
		reply_queue.push_back(it);
	endtask

	// address and request code go out; CRC is seeded from both
	task automatic issue_request();
		crc_run   = crc_byte(crc_byte(16'h0000, dev_addr), code_saved);
		frame_pos = 3'd0;
		value_acc = 32'd0;
		active    = 1'b1;
		queue_result(KIND_TX, dev_addr, 32'd0, 8'd0, 1'b0, 1'b0);
		queue_result(KIND_TX, code_saved, 32'd0, 8'd0, 1'b0, 1'b1);
	endtask

	task automatic fail_attempt();
		if (retries_left != 8'd0) begin
			retries_left = retries_left - 8'd1;
			issue_request();
		end else begin
			active    = 1'b0;
			frame_pos = 3'd0;
			queue_result(KIND_DONE, 8'd0, 32'd0, status_seen, 1'b0, 1'b1);
		end
	endtask

	task automatic predict_item(input cmd_t c, input logic [7:0] code, input logic [7:0] b);
		case (c)
			CMD_START: begin
				code_saved   = code;
				retries_left = retry_limit;
				status_seen  = 8'd0;
				crc_hi       = 8'd0;
				issue_request();
			end
			CMD_TIMEOUT: begin
				if (active)
					fail_attempt();
			end
			CMD_BYTE: begin
				if (active) begin
					case (frame_pos)
						3'd0, 3'd1, 3'd2, 3'd3: begin
							value_acc = {value_acc[23:0], b};
							crc_run   = crc_byte(crc_run, b);
							frame_pos = frame_pos + 3'd1;
						end
						3'd4: begin
							status_seen = b;
							crc_run     = crc_byte(crc_run, b);
							frame_pos   = 3'd5;
						end
						3'd5: begin
							crc_hi    = b;
							frame_pos = 3'd6;
						end
						default: begin
							if (crc_run == {crc_hi, b}) begin
								active    = 1'b0;
								frame_pos = 3'd0;
								queue_result(KIND_DONE, 8'd0, value_acc, status_seen, 1'b1, 1'b1);
							end else begin
								fail_attempt();
							end
						end
					endcase
				end
			end
			default: ;
		endcase
	endtask

	task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		item_t want;
		if (!arst_n) begin
			dev_addr     = 8'd128;
			retry_limit  = 8'd2;
			crc_run      = 16'd0;
			frame_pos    = 3'd0;
			value_acc    = 32'd0;
			status_seen  = 8'd0;
			crc_hi       = 8'd0;
			retries_left = 8'd0;
			code_saved   = 8'd0;
			active       = 1'b0;
			reply_queue.delete();
			mismatches   = 0;
			outstanding  = 0;
		end else begin
			if (cfg_we) begin
				if (reg_idx_t'(cfg_index) == REG_DEVICE_ADDRESS)
					dev_addr = cfg_data;
				else
					retry_limit = cfg_data;
			end
			if (in_valid && !in_stall)
				predict_item(cmd_t'(command), request_code, rx_byte);
			if (out_valid && !out_stall) begin
				if (reply_queue.size() == 0) begin
					$error("result item with none expected: kind %0d tx 0x%0h value 0x%0h",
						kind, tx_byte, reply_value);
					mismatches++;
				end else begin
					want = reply_queue.pop_front();
					check_field("kind", want.kind, kind);
					check_field("tx_byte", want.tx_byte, tx_byte);
					check_field("reply_value", want.reply_value, reply_value);
					check_field("reply_status", want.reply_status, reply_status);
					check_field("reply_valid", want.reply_valid, reply_valid);
					check_field("last", want.last, last);
				end
			end
			outstanding = reply_queue.size();
		end
	end

endmodule

>>> test/testbench.sv
`timescale 1ns / 1ps
// Top of the framed reply reader testbench: clock, reset, register writes and
// request/reply stimulus; the verdict comes from the reply checker's count.
// Depends on crcfr_pkg, crcfr_reply_checker and crc_framed_reply_reader_core.
module testbench;
	import crcfr_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic        cfg_index;
	logic [7:0]  cfg_data;
	logic        in_valid;
	logic        in_stall;
	logic [1:0]  command;
	logic [7:0]  request_code;
	logic [7:0]  rx_byte;
	logic        out_valid;
	logic        out_stall;
	logic        kind;
	logic [7:0]  tx_byte;
	logic [31:0] reply_value;
	logic [7:0]  reply_status;
	logic        reply_valid;
	logic        last;

	int          mismatches;
	int          outstanding;

	// stimulus-side view: needed to build replies whose CRC matches
	logic [7:0]  addr_now;
	logic [7:0]  code_now;
	int          budget_now;
	int          sent;
	bit          gaps_on;
	bit          stall_on;

	crc_framed_reply_reader_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.command      (command),
		.request_code (request_code),
		.rx_byte      (rx_byte),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.kind         (kind),
		.tx_byte      (tx_byte),
		.reply_value  (reply_value),
		.reply_status (reply_status),
		.reply_valid  (reply_valid),
		.last         (last)
	);

	crcfr_reply_checker reply_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.command      (command),
		.request_code (request_code),
		.rx_byte      (rx_byte),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.kind         (kind),
		.tx_byte      (tx_byte),
		.reply_value  (reply_value),
		.reply_status (reply_status),
		.reply_valid  (reply_valid),
		.last         (last),
		.mismatches   (mismatches),
		.outstanding  (outstanding)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// hard stop well past the slowest legal run
	initial begin
		#5_000_000;
		$display("Verification failed");
		$finish;
	end

	// receiver back-pressure: random stall bursts, off for the final phase
	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_on && $urandom_range(0, 7) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 12)) @(negedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	// bytewise CRC-16, MSB first, used to build well-formed replies
	function automatic logic [15:0] fold_byte(input logic [15:0] acc, input logic [7:0] b);
		logic [15:0] r;
		r = acc ^ {b, 8'h00};
		repeat (8) r = r[15] ? ({r[14:0], 1'b0} ^ CRC_POLY) : {r[14:0], 1'b0};
		return r;
	endfunction

	// one item on the input channel; payload holds until accepted
	task automatic drive_item(input cmd_t c, input logic [7:0] code, input logic [7:0] b);
		@(negedge clk);
		if (gaps_on && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(negedge clk);
		end
		in_valid     <= 1'b1;
		command      <= c;
		request_code <= code;
		rx_byte      <= b;
		if (c == CMD_START)
			code_now = code;
		do @(posedge clk); while (in_stall);
		sent++;
	endtask

	task automatic send_byte(input logic [7:0] b);
		drive_item(CMD_BYTE, 8'($urandom_range(0, 255)), b);
	endtask

	task automatic send_timeout();
		drive_item(CMD_TIMEOUT, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
	endtask

	task automatic send_start(input logic [7:0] code);
		drive_item(CMD_START, code, 8'($urandom_range(0, 255)));
	endtask

	// full reply frame: value, status, CRC; spoil damages the CRC bytes
	task automatic send_reply(input logic [31:0] v, input logic [7:0] st, input bit spoil);
		logic [15:0] crc;
		crc = fold_byte(fold_byte(16'h0000, addr_now), code_now);
		for (int i = 3; i >= 0; i--)
			crc = fold_byte(crc, v[8*i +: 8]);
		crc = fold_byte(crc, st);
		if (spoil)
			crc = crc ^ 16'($urandom_range(1, 65535));
		for (int i = 3; i >= 0; i--)
			send_byte(v[8*i +: 8]);
		send_byte(st);
		send_byte(crc[15:8]);
		send_byte(crc[7:0]);
	endtask

	// n random bytes of a frame, then the receive timeout
	task automatic send_partial(input int n);
		repeat (n) send_byte(8'($urandom_range(0, 255)));
		send_timeout();
	endtask

	task automatic send_noise();
		drive_item(cmd_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
			8'($urandom_range(0, 255)));
	endtask

	// drop valid, wait for every expected result, then cover the pipe latency
	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (outstanding != 0) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [7:0] d);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= d;
		@(negedge clk);
		cfg_we    <= 1'b0;
		if (idx == REG_DEVICE_ADDRESS)
			addr_now = d;
		else
			budget_now = d;
	endtask

	// one request: attempts end on a good reply or when the budget runs out
	task automatic run_request();
		int pick;
		send_start(8'($urandom_range(0, 255)));
		for (int a = 0; a <= budget_now; a++) begin
			pick = $urandom_range(0, 9);
			if (pick < 5) begin
				send_reply($urandom(), 8'($urandom_range(0, 255)), 1'b0);
				return;
			end else if (pick < 7) begin
				send_reply($urandom(), 8'($urandom_range(0, 255)), 1'b1);
			end else if (pick < 9) begin
				send_partial($urandom_range(0, 6));
			end else begin
				// stray item mid-frame, then let the attempt time out
				send_noise();
				send_timeout();
			end
		end
	endtask

	initial begin
		arst_n       = 1'b0;
		cfg_we       = 1'b0;
		cfg_index    = 1'b0;
		cfg_data     = 8'd0;
		in_valid     = 1'b0;
		command      = 2'd0;
		request_code = 8'd0;
		rx_byte      = 8'd0;
		addr_now     = 8'd128;
		code_now     = 8'd0;
		budget_now   = 2;
		sent         = 0;
		gaps_on      = 1'b1;
		stall_on     = 1'b1;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;

		// idle: reserved command, stray byte and timeout all give nothing
		drive_item(CMD_NONE, 8'hFF, 8'hFF);
		send_byte(8'hFF);
		send_timeout();
		// clean request, all-ones value and status
		send_start(8'h00);
		send_reply(32'hFFFF_FFFF, 8'hFF, 1'b0);
		// timeout, bad CRC, then a cut-off frame exhausts the default budget;
		// the failure carries the status of the bad frame
		send_start(8'hFF);
		send_timeout();
		send_reply(32'h1234_5678, 8'h5A, 1'b1);
		send_partial(1);
		// restart while a frame is half received
		send_start(8'h3C);
		send_byte(8'hA5);
		send_start(8'hC3);
		send_reply(32'h0000_0000, 8'h00, 1'b0);
		settle();

		// zero budget: a single timeout ends the request
		write_reg(REG_DEVICE_ADDRESS, 8'h00);
		write_reg(REG_RETRY_BUDGET, 8'h00);
		send_start(8'h81);
		send_timeout();
		settle();

		// top of both registers: three resends, then success
		write_reg(REG_DEVICE_ADDRESS, 8'hFF);
		write_reg(REG_RETRY_BUDGET, 8'hFF);
		send_start(8'h7E);
		repeat (3) send_timeout();
		send_reply(32'h8000_0001, 8'h01, 1'b0);
		settle();

		// random phases with fresh settings; the last one runs without idling
		for (int phase = 0; phase < 5; phase++) begin
			int goal;
			goal = sent + 230;
			write_reg(REG_DEVICE_ADDRESS, 8'($urandom_range(0, 255)));
			write_reg(REG_RETRY_BUDGET, 8'($urandom_range(0, 3)));
			if (phase == 4) begin
				gaps_on  = 1'b0;
				stall_on = 1'b0;
			end
			while (sent < goal) begin
				if ($urandom_range(0, 9) == 0)
					send_noise();
				else
					run_request();
			end
			settle();
		end

		if (mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

>>> crc_framed_reply_reader_core.f
rtl/crcfr_pkg.sv
rtl/crcfr_out_fifo.sv
rtl/crc_framed_reply_reader_core.sv
test/crcfr_reply_checker.sv
test/testbench.sv
